[design/hsl2rgb_pkg.sv]
// shared types and constants for the hsl to rgb converter
package hsl2rgb_pkg;

	localparam int FRAC_W = 9;
	localparam int HUE_W = 9;
	localparam int CHAN_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [FRAC_W-1:0] FULL_SCALE = 9'd256;
	localparam logic [HUE_W-1:0] MAX_HUE = 9'd359;

	localparam logic [FRAC_W-1:0] SAT_RESET = 9'd205;
	localparam logic [FRAC_W-1:0] LIGHT_RESET = 9'd128;

	// ceil(2^28 / 60); exact floor division for products below 2^22
	localparam int RECIP_W = 23;
	localparam logic [RECIP_W-1:0] RECIP_60 = 23'd4473925;
	localparam int RECIP_SHIFT = 28;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SATURATION = 2'd0,
		REG_LIGHTNESS  = 2'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		logic [FRAC_W-1:0] sat;
		logic [FRAC_W-1:0] light;
	} color_cfg_t;

endpackage

[design/hsl2rgb_cfg.sv]
// saturation and lightness registers, clamped to full scale on read
module hsl2rgb_cfg
	import hsl2rgb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output color_cfg_t            cfg
);

	logic [FRAC_W-1:0] sat_q;
	logic [FRAC_W-1:0] light_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q   <= SAT_RESET;
			light_q <= LIGHT_RESET;
		end else if (cfg_wr_en) begin
			// indexes past the register list are dropped
			if (cfg_index == REG_SATURATION) begin
				sat_q <= cfg_data;
			end
			if (cfg_index == REG_LIGHTNESS) begin
				light_q <= cfg_data;
			end
		end
	end

	assign cfg.sat   = (sat_q > FULL_SCALE) ? FULL_SCALE : sat_q;
	assign cfg.light = (light_q > FULL_SCALE) ? FULL_SCALE : light_q;

endmodule

[design/hsl_to_rgb_converter.sv]
// hsl to rgb converter top level: six-stage pipeline
//
// A request is a hue in whole degrees on hue, taken at a rising edge with
// start high and busy low. busy never rises, so a new hue can be issued on
// every cycle. Hues above 359 are treated as 359.
// Saturation and lightness come from two registers written through
// cfg_wr_en / cfg_index / cfg_data (index 0 saturation, index 1 lightness,
// units of 1/256, values above 256 act as 256); write them only while no
// request is in flight.
// Each request yields one result on red, green and blue, marked by done
// for exactly one cycle once it leaves the last pipeline stage. Throughput is
// one result per cycle; the depth is set by the three chained multiplies
// (chroma, hue ramp, divide by 60 as reciprocal) plus the sector select
// and the final scale by 255.
// The receiver has no way to hold results off; each is shown once.
// Reset clears all stage valid bits, so nothing is in flight afterward,
// and loads saturation 205 and lightness 128.
module hsl_to_rgb_converter
	import hsl2rgb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [HUE_W-1:0]      hue,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [CHAN_W-1:0]     red,
	output logic [CHAN_W-1:0]     green,
	output logic [CHAN_W-1:0]     blue
);

	localparam int C_W = 17;      // chroma and offset, units of 1/65536
	localparam int TRI_W = 6;     // hue ramp 0..60
	localparam int V_W = C_W + TRI_W - 1; // c * tri fits in 22 bits
	localparam int P_W = V_W + RECIP_W;
	localparam int SCL_W = C_W + CHAN_W;

	color_cfg_t cfg;

	hsl2rgb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic in_acc;
	assign busy   = 1'b0;
	assign in_acc = start && !busy;

	// stage 1 inputs: hue clamp, sector, ramp, chroma span
	logic [HUE_W-1:0]  h_cl;
	logic [HUE_W-1:0]  hm;
	logic [TRI_W-1:0]  tri_d;
	sector_t           sec_d;
	logic [FRAC_W-1:0] span_d;

	always_comb begin
		h_cl = (hue > MAX_HUE) ? MAX_HUE : hue;
		priority if (h_cl >= 9'd240) begin
			hm = h_cl - 9'd240;
		end else if (h_cl >= 9'd120) begin
			hm = h_cl - 9'd120;
		end else begin
			hm = h_cl;
		end
		tri_d = (hm >= 9'd60) ? TRI_W'(9'd120 - hm) : TRI_W'(hm);
		priority if (h_cl < 9'd60) begin
			sec_d = SEC_RED_YEL;
		end else if (h_cl < 9'd120) begin
			sec_d = SEC_YEL_GRN;
		end else if (h_cl < 9'd180) begin
			sec_d = SEC_GRN_CYN;
		end else if (h_cl < 9'd240) begin
			sec_d = SEC_CYN_BLU;
		end else if (h_cl < 9'd300) begin
			sec_d = SEC_BLU_MAG;
		end else begin
			sec_d = SEC_MAG_RED;
		end
		// 256 - |2L - 256|
		if (cfg.light <= 9'd128) begin
			span_d = FRAC_W'({cfg.light, 1'b0});
		end else begin
			span_d = FRAC_W'(10'd512 - {cfg.light, 1'b0});
		end
	end

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	logic [TRI_W-1:0]  tri_s1, tri_s2;
	sector_t           sec_s1, sec_s2, sec_s3, sec_s4, sec_s5;
	logic [FRAC_W-1:0] span_s1, sat_s1, light_s1, light_s2;
	logic [C_W-1:0]    c_s2, c_s3, c_s4;
	logic [V_W-1:0]    v_s3;
	logic [C_W-1:0]    m_s3, m_s4;
	logic [C_W-1:0]    x_s4;
	logic [C_W-1:0]    sum_r_s5, sum_g_s5, sum_b_s5;
	logic [CHAN_W-1:0] red_s6, green_s6, blue_s6;

	logic [2*FRAC_W-1:0] c_prod;
	logic [C_W+TRI_W-1:0] v_prod;
	logic [P_W-1:0]      x_prod;
	logic [C_W-1:0]      m_d;
	logic [C_W-1:0]      comp_r, comp_g, comp_b;
	logic [SCL_W-1:0]    scl_r, scl_g, scl_b;

	assign c_prod = (2*FRAC_W)'(span_s1) * (2*FRAC_W)'(sat_s1);
	assign v_prod = (C_W+TRI_W)'(c_s2) * (C_W+TRI_W)'(tri_s2);
	assign m_d    = {light_s2, 8'd0} - {1'b0, c_s2[C_W-1:1]};
	assign x_prod = P_W'(v_s3) * P_W'(RECIP_60);

	always_comb begin
		unique case (sec_s4)
			SEC_RED_YEL: begin comp_r = c_s4; comp_g = x_s4; comp_b = '0;   end
			SEC_YEL_GRN: begin comp_r = x_s4; comp_g = c_s4; comp_b = '0;   end
			SEC_GRN_CYN: begin comp_r = '0;   comp_g = c_s4; comp_b = x_s4; end
			SEC_CYN_BLU: begin comp_r = '0;   comp_g = x_s4; comp_b = c_s4; end
			SEC_BLU_MAG: begin comp_r = x_s4; comp_g = '0;   comp_b = c_s4; end
			default:     begin comp_r = c_s4; comp_g = '0;   comp_b = x_s4; end
		endcase
	end

	// times 255 as shift and subtract
	assign scl_r = {sum_r_s5, 8'd0} - SCL_W'(sum_r_s5);
	assign scl_g = {sum_g_s5, 8'd0} - SCL_W'(sum_g_s5);
	assign scl_b = {sum_b_s5, 8'd0} - SCL_W'(sum_b_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		tri_s1   <= tri_d;
		sec_s1   <= sec_d;
		span_s1  <= span_d;
		sat_s1   <= cfg.sat;
		light_s1 <= cfg.light;

		c_s2     <= C_W'(c_prod);
		tri_s2   <= tri_s1;
		sec_s2   <= sec_s1;
		light_s2 <= light_s1;

		v_s3     <= V_W'(v_prod);
		m_s3     <= m_d;
		c_s3     <= c_s2;
		sec_s3   <= sec_s2;

		x_s4     <= x_prod[RECIP_SHIFT +: C_W];
		c_s4     <= c_s3;
		m_s4     <= m_s3;
		sec_s4   <= sec_s3;

		sum_r_s5 <= comp_r + m_s4;
		sum_g_s5 <= comp_g + m_s4;
		sum_b_s5 <= comp_b + m_s4;
		sec_s5   <= sec_s4;

		red_s6   <= scl_r[16 +: CHAN_W];
		green_s6 <= scl_g[16 +: CHAN_W];
		blue_s6  <= scl_b[16 +: CHAN_W];
	end

	assign done  = valid_s6;
	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

	// every result traces back to an earlier accepted request
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(in_acc, 6))
		else $error("result without matching request");

	// secondary component never exceeds chroma
	a_x_le_c: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (x_s4 <= c_s4))
		else $error("secondary component above chroma");

	// channel sums stay within full scale so the scaled value fits 8 bits
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (sum_r_s5 <= 17'd65536 && sum_g_s5 <= 17'd65536
			&& sum_b_s5 <= 17'd65536))
		else $error("channel sum out of range");

	// sector code only takes the six defined values when in flight
	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> (sec_s5 != 3'd6 && sec_s5 != 3'd7))
		else $error("bad sector code");

endmodule
